### rtl/plr_pkg.sv
// Shared types, constants and helpers of the greedy piecewise-linear segmenter.
package plr_pkg;

   localparam int WIDE_BITS      = 128;
   localparam int Q_BITS         = 64;
   localparam int FRAC_BITS      = 16;
   localparam int SLOPE_FRAC     = 32;
   localparam int MUL_M_BITS     = 96;
   localparam int MUL_ACC_BITS   = Q_BITS + MUL_M_BITS;
   localparam int START_BITS     = 48;
   localparam int GAMMA_BITS     = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [WIDE_BITS-1:0] wide_type;
   typedef logic [Q_BITS-1:0]    q_type;

   localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 32'd524288;
   localparam q_type Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam q_type Q_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [0:0] {
      OP_ADD    = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ERROR_BOUND = 1'b0,
      CSR_RESTART     = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_NEED2 = 4'b0001,
      PH_NEED1 = 4'b0010,
      PH_READY = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   // Saturate a 128-bit two's complement value to the signed 64-bit range.
   function automatic q_type sat_q(input wide_type v);
      if (v[WIDE_BITS-1:Q_BITS-1] == {(WIDE_BITS-Q_BITS+1){v[Q_BITS-1]}}) begin
         return v[Q_BITS-1:0];
      end else begin
         return v[WIDE_BITS-1] ? Q_MIN : Q_MAX;
      end
   endfunction

   // Sign-extend a 64-bit value to 128 bits.
   function automatic wide_type sext_q(input q_type v);
      return {{(WIDE_BITS-Q_BITS){v[Q_BITS-1]}}, v};
   endfunction

endpackage

### rtl/plr_mul.sv
// Bit-serial signed multiplier that returns floor(a * m / 2^32) in 128 bits.
module plr_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  plr_pkg::q_type    mult_a,
   input  plr_pkg::wide_type mult_m,
   output logic              done,
   output plr_pkg::wide_type product
);

   localparam int CNT_BITS = $clog2(plr_pkg::MUL_M_BITS);
   localparam int ACC_BITS = plr_pkg::MUL_ACC_BITS;
   localparam int M_BITS   = plr_pkg::MUL_M_BITS;

   logic [ACC_BITS-1:0] acc_ff, acc_in, a_ff, a_in, addend;
   logic [M_BITS-1:0]   m_ff, m_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   // The multiplier word is scanned from its sign bit down; the sign bit has negative weight.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      addend  = '0;
      if (m_ff[M_BITS-1]) begin
         addend = (cnt_ff == CNT_BITS'(M_BITS-1)) ? (~a_ff + ACC_BITS'(1)) : a_ff;
      end
      if (start) begin
         a_in    = {{(ACC_BITS-plr_pkg::Q_BITS){mult_a[plr_pkg::Q_BITS-1]}}, mult_a};
         m_in    = mult_m[M_BITS-1:0];
         acc_in  = '0;
         cnt_in  = CNT_BITS'(M_BITS-1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[ACC_BITS-2:0], 1'b0} + addend;
         m_in   = {m_ff[M_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff[ACC_BITS-1:plr_pkg::SLOPE_FRAC];

endmodule

### rtl/plr_div.sv
// Bit-serial restoring divider: signed 128-bit quotient truncated and saturated to 64 bits.
module plr_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  plr_pkg::wide_type num,
   input  plr_pkg::wide_type den,
   output logic              done,
   output plr_pkg::q_type    quotient
);

   localparam int W        = plr_pkg::WIDE_BITS;
   localparam int CNT_BITS = $clog2(W);

   plr_pkg::wide_type r_ff, r_in, q_ff, q_in, d_ff, d_in, r_sh;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic neg_n_ff, neg_n_in, neg_d_ff, neg_d_in, dz_ff, dz_in, nz_ff, nz_in;
   logic ge;

   always_comb begin
      r_in     = r_ff;
      q_in     = q_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_n_in = neg_n_ff;
      neg_d_in = neg_d_ff;
      dz_in    = dz_ff;
      nz_in    = nz_ff;
      r_sh     = {r_ff[W-2:0], q_ff[W-1]};
      ge       = (r_sh >= d_ff);
      if (start) begin
         neg_n_in = num[W-1];
         neg_d_in = den[W-1];
         dz_in    = (den == '0);
         nz_in    = (num == '0);
         q_in     = num[W-1] ? (~num + W'(1)) : num;
         d_in     = den[W-1] ? (~den + W'(1)) : den;
         r_in     = '0;
         cnt_in   = CNT_BITS'(W-1);
         busy_in  = (den != '0);
         done_in  = (den == '0);
      end else if (busy_ff) begin
         r_in   = ge ? (r_sh - d_ff) : r_sh;
         q_in   = {q_ff[W-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (dz_ff) begin
         quotient = nz_ff ? '0 : (neg_n_ff ? plr_pkg::Q_MIN : plr_pkg::Q_MAX);
      end else if (neg_n_ff ^ neg_d_ff) begin
         if (q_ff[W-1:plr_pkg::Q_BITS] != '0 || q_ff[plr_pkg::Q_BITS-1:0] > plr_pkg::Q_MIN) begin
            quotient = plr_pkg::Q_MIN;
         end else begin
            quotient = ~q_ff[plr_pkg::Q_BITS-1:0] + plr_pkg::Q_BITS'(1);
         end
      end else if (q_ff[W-1:plr_pkg::Q_BITS-1] != '0) begin
         quotient = plr_pkg::Q_MAX;
      end else begin
         quotient = q_ff[plr_pkg::Q_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff     <= r_in;
      q_ff     <= q_in;
      d_ff     <= d_in;
      cnt_ff   <= cnt_in;
      neg_n_ff <= neg_n_in;
      neg_d_ff <= neg_d_in;
      dz_ff    <= dz_in;
      nz_ff    <= nz_in;
   end

   assign done = done_ff;

endmodule

### rtl/greedy_plr_segmenter.sv
// Greedy piecewise-linear segmenter: sequencer, segment state and the shared serial units.
// A first point, or a finish with fewer than two points, uses neither serial unit; a finish that
// closes a segment uses one multiplication; the second point of a segment up to three divisions
// and three multiplications; a point that narrows the cone two multiplications and up to two line
// fits; a break three multiplications, and with restart the line fits of a new segment as well.
// One word at a time: a new word is taken only in the idle step; the serial units set the pace.
// Reset is synchronous: it empties the segment, idles the sequencer and restores the registers.
module greedy_plr_segmenter #(
   parameter int KEY_BITS      = 48,
   parameter int POSITION_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_operation,
   input  logic [KEY_BITS-1:0]                    req_key_x,
   input  logic [POSITION_BITS-1:0]               req_position_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_segment_valid,
   output logic [plr_pkg::START_BITS-1:0]         rsp_start_key,
   output logic signed [plr_pkg::Q_BITS-1:0]      rsp_segment_slope,
   output logic signed [plr_pkg::Q_BITS-1:0]      rsp_segment_intercept,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [plr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [plr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int W = plr_pkg::WIDE_BITS;

   // Sequencer steps. The line-fit steps are a subroutine with a stored return step.
   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_RD_LL    = 13'b0000000000010,
      ST_RD_LU    = 13'b0000000000100,
      ST_RD_DEC   = 13'b0000000001000,
      ST_NR_LOW   = 13'b0000000010000,
      ST_EM_MUL   = 13'b0000000100000,
      ST_SU_LOW   = 13'b0000001000000,
      ST_SU_UP    = 13'b0000010000000,
      ST_SU_CROSS = 13'b0000100000000,
      ST_SU_CY    = 13'b0001000000000,
      ST_ML_DIV   = 13'b0010000000000,
      ST_ML_MUL   = 13'b0100000000000,
      ST_PUSH     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   plr_pkg::phase_type phase_ff, phase_in;
   plr_pkg::op_type op_ff, op_in;
   logic launched_ff, launched_in;
   logic [plr_pkg::GAMMA_BITS-1:0] gamma_ff, gamma_in;
   logic restart_ff, restart_in;

   logic [KEY_BITS-1:0]      cur_x_ff, cur_x_in, anchor_x_ff, anchor_x_in;
   logic [KEY_BITS-1:0]      prev_x_ff, prev_x_in, sp_x_ff, sp_x_in;
   logic [POSITION_BITS-1:0] cur_y_ff, cur_y_in, anchor_y_ff, anchor_y_in;
   logic [POSITION_BITS-1:0] prev_y_ff, prev_y_in, sp_y_ff, sp_y_in;

   plr_pkg::q_type ls_ff, ls_in, li_ff, li_in, us_ff, us_in, ui_ff, ui_in;
   plr_pkg::q_type cx_ff, cx_in, cy_ff, cy_in, ml_slope_ff, ml_slope_in;
   plr_pkg::wide_type t_lo_ff, t_lo_in, t_up_ff, t_up_in;
   plr_pkg::wide_type ml_x1_ff, ml_x1_in, ml_y1_ff, ml_y1_in;
   plr_pkg::wide_type ml_x2_ff, ml_x2_in, ml_y2_ff, ml_y2_in;
   logic ml_upper_ff, ml_upper_in;

   logic res_valid_ff, res_valid_in;
   logic [plr_pkg::START_BITS-1:0] res_start_ff, res_start_in;
   plr_pkg::q_type res_slope_ff, res_slope_in, res_icpt_ff, res_icpt_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_seg_ff, rsp_seg_in;
   logic [plr_pkg::START_BITS-1:0] rsp_start_ff, rsp_start_in;
   plr_pkg::q_type rsp_slope_ff, rsp_slope_in, rsp_icpt_ff, rsp_icpt_in;

   // Shared unit ports.
   logic mul_go, mul_done, div_go, div_done;
   plr_pkg::q_type mul_a, div_q;
   plr_pkg::wide_type mul_m, mul_p, div_n, div_d;

   // Points in Q48.16 and the cone edges shifted by the error bound.
   plr_pkg::wide_type gamma_w, cur_xq, cur_yq, yu, yl, sp_xq, sp_yq;
   plr_pkg::wide_type anchor_xw, anchor_yq, avg_sum;
   plr_pkg::q_type avg;
   logic above_low, below_up;

   assign gamma_w   = W'(gamma_ff);
   assign cur_xq    = W'(cur_x_ff) << plr_pkg::FRAC_BITS;
   assign cur_yq    = W'(cur_y_ff) << plr_pkg::FRAC_BITS;
   assign sp_xq     = W'(sp_x_ff) << plr_pkg::FRAC_BITS;
   assign sp_yq     = W'(sp_y_ff) << plr_pkg::FRAC_BITS;
   assign anchor_xw = W'(anchor_x_ff);
   assign anchor_yq = W'(anchor_y_ff) << plr_pkg::FRAC_BITS;
   assign yu        = cur_yq + gamma_w;
   assign yl        = cur_yq - gamma_w;
   assign avg_sum   = plr_pkg::sext_q(ls_ff) + plr_pkg::sext_q(us_ff);
   assign avg       = avg_sum[plr_pkg::Q_BITS:1];
   assign above_low = $signed(cur_yq) > $signed(t_lo_ff);
   assign below_up  = $signed(cur_yq) < $signed(t_up_ff);

   // A unit is started once on entry to a step that needs it.
   always_comb begin
      mul_go = 1'b0;
      div_go = 1'b0;
      if (!launched_ff) begin
         mul_go = (state_ff == ST_RD_LL) || (state_ff == ST_RD_LU) ||
                  (state_ff == ST_EM_MUL) || (state_ff == ST_SU_CY) ||
                  (state_ff == ST_ML_MUL);
         div_go = (state_ff == ST_ML_DIV) || ((state_ff == ST_SU_CROSS) && (us_ff != ls_ff));
      end
   end

   // Operand selection for the shared multiplier and divider.
   always_comb begin
      mul_a = ml_slope_ff;
      mul_m = ml_x1_ff;
      div_n = (ml_y2_ff - ml_y1_ff) << plr_pkg::SLOPE_FRAC;
      div_d = ml_x2_ff - ml_x1_ff;
      case (state_ff)
         ST_RD_LL: begin
            mul_a = ls_ff;
            mul_m = cur_xq;
         end
         ST_RD_LU: begin
            mul_a = us_ff;
            mul_m = cur_xq;
         end
         ST_EM_MUL: begin
            mul_a = avg;
            mul_m = plr_pkg::sext_q(cx_ff);
         end
         ST_SU_CY: begin
            mul_a = us_ff;
            mul_m = plr_pkg::sext_q(cx_ff);
         end
         ST_SU_CROSS: begin
            div_n = (plr_pkg::sext_q(li_ff) - plr_pkg::sext_q(ui_ff)) << plr_pkg::SLOPE_FRAC;
            div_d = plr_pkg::sext_q(us_ff) - plr_pkg::sext_q(ls_ff);
         end
         default: begin
         end
      endcase
   end

   plr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go),
      .mult_a  (mul_a),
      .mult_m  (mul_m),
      .done    (mul_done),
      .product (mul_p)
   );

   plr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .num      (div_n),
      .den      (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sequencer and segment state.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      launched_in  = launched_ff;
      gamma_in     = gamma_ff;
      restart_in   = restart_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      anchor_x_in  = anchor_x_ff;
      anchor_y_in  = anchor_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      sp_x_in      = sp_x_ff;
      sp_y_in      = sp_y_ff;
      ls_in        = ls_ff;
      li_in        = li_ff;
      us_in        = us_ff;
      ui_in        = ui_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      ml_slope_in  = ml_slope_ff;
      t_lo_in      = t_lo_ff;
      t_up_in      = t_up_ff;
      ml_x1_in     = ml_x1_ff;
      ml_y1_in     = ml_y1_ff;
      ml_x2_in     = ml_x2_ff;
      ml_y2_in     = ml_y2_ff;
      ml_upper_in  = ml_upper_ff;
      res_valid_in = res_valid_ff;
      res_start_in = res_start_ff;
      res_slope_in = res_slope_ff;
      res_icpt_in  = res_icpt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_start_in = rsp_start_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_icpt_in  = rsp_icpt_ff;

      if (mul_go || div_go) begin
         launched_in = 1'b1;
      end
      if (mul_done || div_done) begin
         launched_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (plr_pkg::csr_index_type'(csr_index))
            plr_pkg::CSR_ERROR_BOUND: gamma_in = csr_wdata[plr_pkg::GAMMA_BITS-1:0];
            plr_pkg::CSR_RESTART:     restart_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = plr_pkg::op_type'(req_operation);
               cur_x_in     = req_key_x;
               cur_y_in     = req_position_y;
               res_valid_in = 1'b0;
               res_start_in = '0;
               res_slope_in = '0;
               res_icpt_in  = '0;
               state_in     = ST_PUSH;
               if (plr_pkg::op_type'(req_operation) == plr_pkg::OP_FINISH) begin
                  phase_in = plr_pkg::PH_DONE;
                  if (phase_ff == plr_pkg::PH_NEED1) begin
                     // A lone anchor becomes a flat segment at its own position.
                     res_valid_in = 1'b1;
                     res_start_in = anchor_xw[plr_pkg::START_BITS-1:0];
                     res_icpt_in  = plr_pkg::sat_q(anchor_yq);
                  end else if (phase_ff == plr_pkg::PH_READY) begin
                     state_in = ST_EM_MUL;
                  end
               end else begin
                  case (phase_ff)
                     plr_pkg::PH_NEED2: begin
                        anchor_x_in = req_key_x;
                        anchor_y_in = req_position_y;
                        phase_in    = plr_pkg::PH_NEED1;
                     end
                     plr_pkg::PH_NEED1: begin
                        sp_x_in  = anchor_x_ff;
                        sp_y_in  = anchor_y_ff;
                        state_in = ST_SU_LOW;
                     end
                     plr_pkg::PH_READY: state_in = ST_RD_LL;
                     default: begin
                     end
                  endcase
               end
            end
         end

         // Evaluate both bounding lines at the new key.
         ST_RD_LL: begin
            if (mul_done) begin
               t_lo_in  = mul_p + plr_pkg::sext_q(li_ff);
               state_in = ST_RD_LU;
            end
         end
         ST_RD_LU: begin
            if (mul_done) begin
               t_up_in  = mul_p + plr_pkg::sext_q(ui_ff);
               state_in = ST_RD_DEC;
            end
         end

         // Strictly inside the cone narrows it; on or outside it closes the segment.
         ST_RD_DEC: begin
            if (!(above_low && below_up)) begin
               state_in = ST_EM_MUL;
            end else if ($signed(yu) < $signed(t_up_ff)) begin
               ml_x1_in    = plr_pkg::sext_q(cx_ff);
               ml_y1_in    = plr_pkg::sext_q(cy_ff);
               ml_x2_in    = cur_xq;
               ml_y2_in    = yu;
               ml_upper_in = 1'b1;
               ret_in      = ST_NR_LOW;
               state_in    = ST_ML_DIV;
            end else begin
               state_in = ST_NR_LOW;
            end
         end
         ST_NR_LOW: begin
            if ($signed(yl) > $signed(t_lo_ff)) begin
               ml_x1_in    = plr_pkg::sext_q(cx_ff);
               ml_y1_in    = plr_pkg::sext_q(cy_ff);
               ml_x2_in    = cur_xq;
               ml_y2_in    = yl;
               ml_upper_in = 1'b0;
               ret_in      = ST_PUSH;
               state_in    = ST_ML_DIV;
            end else begin
               state_in = ST_PUSH;
            end
         end

         // Close the segment: mean slope through the intersection point.
         ST_EM_MUL: begin
            if (mul_done) begin
               res_valid_in = 1'b1;
               res_start_in = anchor_xw[plr_pkg::START_BITS-1:0];
               res_slope_in = avg;
               res_icpt_in  = plr_pkg::sat_q(plr_pkg::sext_q(cy_ff) - mul_p);
               state_in     = ST_PUSH;
               if (op_ff == plr_pkg::OP_ADD) begin
                  if (restart_ff && cur_y_ff[0]) begin
                     sp_x_in  = prev_x_ff;
                     sp_y_in  = prev_y_ff;
                     state_in = ST_SU_LOW;
                  end else begin
                     anchor_x_in = cur_x_ff;
                     anchor_y_in = cur_y_ff;
                     phase_in    = plr_pkg::PH_NEED1;
                  end
               end
            end
         end

         // Open a segment from the start point and the current point.
         ST_SU_LOW: begin
            anchor_x_in = sp_x_ff;
            anchor_y_in = sp_y_ff;
            phase_in    = plr_pkg::PH_READY;
            ml_x1_in    = sp_xq;
            ml_y1_in    = sp_yq + gamma_w;
            ml_x2_in    = cur_xq;
            ml_y2_in    = cur_yq - gamma_w;
            ml_upper_in = 1'b0;
            ret_in      = ST_SU_UP;
            state_in    = ST_ML_DIV;
         end
         ST_SU_UP: begin
            ml_x1_in    = sp_xq;
            ml_y1_in    = sp_yq - gamma_w;
            ml_x2_in    = cur_xq;
            ml_y2_in    = cur_yq + gamma_w;
            ml_upper_in = 1'b1;
            ret_in      = ST_SU_CROSS;
            state_in    = ST_ML_DIV;
         end
         ST_SU_CROSS: begin
            if (us_ff == ls_ff) begin
               // Parallel bounds meet at the start key.
               cx_in    = plr_pkg::sat_q(sp_xq);
               state_in = ST_SU_CY;
            end else if (div_done) begin
               cx_in    = div_q;
               state_in = ST_SU_CY;
            end
         end
         ST_SU_CY: begin
            if (mul_done) begin
               cy_in    = plr_pkg::sat_q(mul_p + plr_pkg::sext_q(ui_ff));
               state_in = ST_PUSH;
            end
         end

         // Line through two points: slope by division, intercept through the first point.
         ST_ML_DIV: begin
            if (div_done) begin
               ml_slope_in = div_q;
               state_in    = ST_ML_MUL;
            end
         end
         ST_ML_MUL: begin
            if (mul_done) begin
               if (ml_upper_ff) begin
                  us_in = ml_slope_ff;
                  ui_in = plr_pkg::sat_q(ml_y1_ff - mul_p);
               end else begin
                  ls_in = ml_slope_ff;
                  li_in = plr_pkg::sat_q(ml_y1_ff - mul_p);
               end
               state_in = ret_ff;
            end
         end

         // Hand the word to the output register once it is free.
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_seg_in   = res_valid_ff;
               rsp_start_in = res_start_ff;
               rsp_slope_in = res_slope_ff;
               rsp_icpt_in  = res_icpt_ff;
               if (op_ff == plr_pkg::OP_ADD) begin
                  prev_x_in = cur_x_ff;
                  prev_y_in = cur_y_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         phase_ff     <= plr_pkg::PH_NEED2;
         launched_ff  <= 1'b0;
         gamma_ff     <= plr_pkg::GAMMA_RESET;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         phase_ff     <= phase_in;
         launched_ff  <= launched_in;
         gamma_ff     <= gamma_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      anchor_x_ff  <= anchor_x_in;
      anchor_y_ff  <= anchor_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      sp_x_ff      <= sp_x_in;
      sp_y_ff      <= sp_y_in;
      ls_ff        <= ls_in;
      li_ff        <= li_in;
      us_ff        <= us_in;
      ui_ff        <= ui_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      ml_slope_ff  <= ml_slope_in;
      t_lo_ff      <= t_lo_in;
      t_up_ff      <= t_up_in;
      ml_x1_ff     <= ml_x1_in;
      ml_y1_ff     <= ml_y1_in;
      ml_x2_ff     <= ml_x2_in;
      ml_y2_ff     <= ml_y2_in;
      ml_upper_ff  <= ml_upper_in;
      res_valid_ff <= res_valid_in;
      res_start_ff <= res_start_in;
      res_slope_ff <= res_slope_in;
      res_icpt_ff  <= res_icpt_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_start_ff <= rsp_start_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_icpt_ff  <= rsp_icpt_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_segment_valid     = rsp_seg_ff;
   assign rsp_start_key         = rsp_start_ff;
   assign rsp_segment_slope     = rsp_slope_ff;
   assign rsp_segment_intercept = rsp_icpt_ff;

endmodule

### bench/tb_greedy_plr_segmenter.sv
// Self-checking testbench of the greedy piecewise-linear segmenter with a built-in predictor.
module tb_greedy_plr_segmenter;

   // Signed 128-bit working width of the predictor and signed 64-bit fixed-point values.
   typedef logic signed [127:0] swide_type;
   typedef logic signed [63:0]  sfix_type;

   // One expected result word.
   typedef struct {
      logic        seg_valid;
      logic [47:0] start;
      sfix_type    slope;
      sfix_type    icpt;
   } seg_word_type;

   // The segment predictor keeps its own copy of the cone and the registers. Each accepted
   // request word queues exactly one expected response word, which check() compares.
   class segment_scoreboard;
      logic [31:0] gamma;
      logic        restart_prev;
      plr_pkg::phase_type phase;
      logic [47:0] anchor_x, prev_x;
      logic [31:0] anchor_y, prev_y;
      sfix_type    lo_slope, lo_icpt, up_slope, up_icpt, cross_x, cross_y;
      seg_word_type segments_due[$];
      int unsigned errors;

      function new();
         gamma = plr_pkg::GAMMA_RESET;
         restart_prev = 1'b0;
         phase = plr_pkg::PH_NEED2;
         anchor_x = '0; prev_x = '0; anchor_y = '0; prev_y = '0;
         lo_slope = '0; lo_icpt = '0; up_slope = '0; up_icpt = '0;
         cross_x = '0; cross_y = '0;
         errors = 0;
      endfunction

      function void set_reg(plr_pkg::csr_index_type idx, logic [31:0] data);
         if (idx == plr_pkg::CSR_ERROR_BOUND) gamma = data;
         else restart_prev = data[0];
      endfunction

      function int pending();
         return segments_due.size();
      endfunction

      function swide_type ext(sfix_type v);
         swide_type r;
         r = v;
         return r;
      endfunction

      function sfix_type sat(swide_type v);
         if (v[127:63] == {65{v[63]}}) return v[63:0];
         return v[127] ? plr_pkg::Q_MIN : plr_pkg::Q_MAX;
      endfunction

      // Quotient truncated toward zero; x/0 saturates by the sign of x, and 0/0 gives 0.
      function sfix_type div_sat(swide_type n, swide_type d);
         if (d == 0) begin
            if (n == 0) return '0;
            return n[127] ? plr_pkg::Q_MIN : plr_pkg::Q_MAX;
         end
         return sat(n / d);
      endfunction

      // floor(a * x / 2^32) with a in Q32.32 and x in Q48.16, split in high and low halves.
      function swide_type mul_q(sfix_type a, swide_type x);
         sfix_type  xh;
         swide_type xl, ph, pl;
         xh = x[95:32];
         xl = {96'b0, x[31:0]};
         ph = ext(a) * ext(xh);
         pl = ext(a) * xl;
         return ph + (pl >>> 32);
      endfunction

      function swide_type line_at(sfix_type a, sfix_type b, swide_type x);
         return mul_q(a, x) + ext(b);
      endfunction

      function swide_type to_q(logic [63:0] k);
         swide_type r;
         r = '0;
         r[79:16] = k;
         return r;
      endfunction

      function void make_line(swide_type x1, swide_type y1, swide_type x2, swide_type y2,
                              output sfix_type slope, output sfix_type icpt);
         slope = div_sat((y2 - y1) <<< 32, x2 - x1);
         icpt = sat(y1 - mul_q(slope, x1));
      endfunction

      function void open_segment(logic [47:0] x0, logic [31:0] y0,
                                 logic [47:0] x1, logic [31:0] y1);
         swide_type g, kx0, ky0, kx1, ky1, dsl;
         g = {96'b0, gamma};
         kx0 = to_q(64'(x0)); ky0 = to_q(64'(y0)); kx1 = to_q(64'(x1)); ky1 = to_q(64'(y1));
         anchor_x = x0;
         anchor_y = y0;
         make_line(kx0, ky0 + g, kx1, ky1 - g, lo_slope, lo_icpt);
         make_line(kx0, ky0 - g, kx1, ky1 + g, up_slope, up_icpt);
         dsl = ext(up_slope) - ext(lo_slope);
         // Parallel bounds meet nowhere; the anchor key stands in for the crossing.
         if (dsl == 0) cross_x = sat(kx0);
         else cross_x = div_sat((ext(lo_icpt) - ext(up_icpt)) <<< 32, dsl);
         cross_y = sat(line_at(up_slope, up_icpt, ext(cross_x)));
      endfunction

      function seg_word_type close_segment();
         seg_word_type w;
         swide_type mean;
         mean = (ext(lo_slope) + ext(up_slope)) >>> 1;
         w.seg_valid = 1'b1;
         w.start = anchor_x;
         w.slope = mean[63:0];
         w.icpt = sat(ext(cross_y) - mul_q(mean[63:0], ext(cross_x)));
         return w;
      endfunction

      function void note_input(plr_pkg::op_type op, logic [47:0] x, logic [31:0] y);
         seg_word_type w;
         swide_type kx, ky, g, yu, yl;
         logic inside_cone;
         w = '{1'b0, 48'b0, 64'sb0, 64'sb0};
         if (op == plr_pkg::OP_FINISH) begin
            if (phase == plr_pkg::PH_NEED1) begin
               w.seg_valid = 1'b1;
               w.start = anchor_x;
               w.icpt = sat(to_q(64'(anchor_y)));
            end else if (phase == plr_pkg::PH_READY) begin
               w = close_segment();
            end
            phase = plr_pkg::PH_DONE;
            segments_due.insert(segments_due.size(), w);
            return;
         end
         case (phase)
            plr_pkg::PH_NEED2: begin
               anchor_x = x;
               anchor_y = y;
               phase = plr_pkg::PH_NEED1;
            end
            plr_pkg::PH_NEED1: begin
               open_segment(anchor_x, anchor_y, x, y);
               phase = plr_pkg::PH_READY;
            end
            plr_pkg::PH_READY: begin
               kx = to_q(64'(x));
               ky = to_q(64'(y));
               g = {96'b0, gamma};
               inside_cone = (ky > line_at(lo_slope, lo_icpt, kx)) &&
                             (ky < line_at(up_slope, up_icpt, kx));
               if (!inside_cone) begin
                  w = close_segment();
                  if (restart_prev && y[0]) begin
                     open_segment(prev_x, prev_y, x, y);
                  end else begin
                     anchor_x = x;
                     anchor_y = y;
                     phase = plr_pkg::PH_NEED1;
                  end
               end else begin
                  yu = ky + g;
                  yl = ky - g;
                  if (yu < line_at(up_slope, up_icpt, kx))
                     make_line(ext(cross_x), ext(cross_y), kx, yu, up_slope, up_icpt);
                  if (yl > line_at(lo_slope, lo_icpt, kx))
                     make_line(ext(cross_x), ext(cross_y), kx, yl, lo_slope, lo_icpt);
               end
            end
            default: ;
         endcase
         prev_x = x;
         prev_y = y;
         segments_due.insert(segments_due.size(), w);
      endfunction

      task report(string field, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 100) $display("segment word error in %s: expected %h, got %h",
                                     field, want, got);
      endtask

      task check(logic sv, logic [47:0] st, sfix_type sl, sfix_type ic);
         seg_word_type w;
         if (segments_due.size() == 0) begin
            report("unexpected word", 64'd0, {63'd0, sv});
            return;
         end
         w = segments_due.pop_front();
         if (sv !== w.seg_valid) report("segment_valid", 64'(w.seg_valid), 64'(sv));
         if (st !== w.start) report("start key", 64'(w.start), 64'(st));
         if (sl !== w.slope) report("segment_slope", w.slope, sl);
         if (ic !== w.icpt) report("segment_intercept", w.icpt, ic);
      endtask
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready, req_operation;
   logic [47:0] req_key_x;
   logic [31:0] req_position_y;
   logic        rsp_valid, rsp_ready, rsp_segment_valid;
   logic [47:0] rsp_start_key;
   logic signed [63:0] rsp_segment_slope, rsp_segment_intercept;
   logic        csr_valid, csr_ready;
   logic [plr_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;

   segment_scoreboard sb = new();
   int unsigned send_idle, recv_idle;
   logic [47:0] walk_key;
   logic [31:0] walk_pos;

   greedy_plr_segmenter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_key_x(req_key_x), .req_position_y(req_position_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_segment_valid(rsp_segment_valid),
      .rsp_start_key(rsp_start_key), .rsp_segment_slope(rsp_segment_slope),
      .rsp_segment_intercept(rsp_segment_intercept),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A generous fixed bound on the run; the slowest legal run stays well below it.
   initial begin
      #(64'd12 * 64'd40_000_000);
      $display("Mismatches found");
      $finish;
   end

   // The result side: check every accepted word, then pick the next ready at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check(rsp_segment_valid, rsp_start_key, rsp_segment_slope,
                  rsp_segment_intercept);
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Offer one request word. Valid is only dropped ahead of an idle gap, so a valid that
   // stays high for the next word never sees two assignments in one step.
   task send_word(plr_pkg::op_type op, logic [47:0] x, logic [31:0] y);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key_x <= x;
      req_position_y <= y;
      do @(posedge clock); while (!req_ready);
      sb.note_input(op, x, y);
   endtask

   // Registers change only once every expected word has come back and the block is idle.
   task write_regs(logic [31:0] bound, logic restart);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= plr_pkg::CSR_ERROR_BOUND;
      csr_wdata <= bound;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(plr_pkg::CSR_ERROR_BOUND, bound);
      csr_index <= plr_pkg::CSR_RESTART;
      csr_wdata <= {31'd0, restart};
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(plr_pkg::CSR_RESTART, {31'd0, restart});
      csr_valid <= 1'b0;
   endtask

   // Mostly a rising walk of points with small noise, so the cone narrows and breaks
   // naturally; now and then a jump, an equal key or a point anywhere in the field range.
   task send_walk(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            walk_key = 48'({$urandom, $urandom});
            walk_pos = $urandom;
         end else begin
            if (pick < 18) walk_key = walk_key;
            else if (pick < 80) walk_key = walk_key + 48'($urandom_range(1, 16));
            else if (pick < 96) walk_key = walk_key + 48'($urandom_range(17, 4096));
            else walk_key = walk_key + 48'({$urandom_range(1, 255), 24'd0});
            if (pick < 90) walk_pos = walk_pos + $urandom_range(0, 3);
            else walk_pos = walk_pos + $urandom_range(0, 5000) - 2500;
         end
         send_word(plr_pkg::OP_ADD, walk_key, walk_pos);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= plr_pkg::OP_ADD;
      req_key_x <= '0;
      req_position_y <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= plr_pkg::CSR_ERROR_BOUND;
      csr_wdata <= '0;
      walk_key = '0;
      walk_pos = '0;
      send_idle = 30;
      recv_idle = 56;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero point, equal keys with and without a rise, field extremes,
      // a flat run, a steep drop and a key going backwards.
      send_word(plr_pkg::OP_ADD, 48'd0, 32'd0);
      send_word(plr_pkg::OP_ADD, 48'd0, 32'd0);
      send_word(plr_pkg::OP_ADD, 48'd0, 32'd5);
      send_word(plr_pkg::OP_ADD, 48'd0, 32'hFFFF_FFFF);
      send_word(plr_pkg::OP_ADD, '1, 32'hFFFF_FFFF);
      send_word(plr_pkg::OP_ADD, '1, 32'd0);
      send_word(plr_pkg::OP_ADD, '1, 32'd1);
      send_word(plr_pkg::OP_ADD, 48'd10, 32'd3);
      send_word(plr_pkg::OP_ADD, 48'd20, 32'd3);
      send_word(plr_pkg::OP_ADD, 48'd30, 32'd3);
      send_word(plr_pkg::OP_ADD, 48'd40, 32'd4);
      send_word(plr_pkg::OP_ADD, 48'd50, 32'd40);
      send_word(plr_pkg::OP_ADD, 48'd51, 32'd41);
      send_word(plr_pkg::OP_ADD, 48'd52, 32'd43);
      send_word(plr_pkg::OP_ADD, 48'd53, 32'd0);
      send_word(plr_pkg::OP_ADD, 48'd7, 32'd9);
      send_word(plr_pkg::OP_ADD, 48'h8000_0000_0000, 32'h8000_0000);
      send_word(plr_pkg::OP_ADD, 48'h8000_0000_0001, 32'h8000_0001);

      // Zero error bound with restart from the previous point on odd positions.
      write_regs(32'd0, 1'b1);
      send_walk(560);

      send_idle = 56;
      recv_idle = 30;
      write_regs(32'hFFFF_FFFF, 1'b0);
      send_walk(200);
      write_regs($urandom_range(32'h1_0000, 32'h10_0000), 1'b1);
      send_walk(360);

      send_idle = 0;
      recv_idle = 0;
      write_regs($urandom_range(1, 32'h8_0000), 1'($urandom_range(0, 1)));
      send_walk(560);

      // Flush the open segment; after that the block only answers with empty words.
      send_word(plr_pkg::OP_FINISH, walk_key, walk_pos);
      send_word(plr_pkg::OP_ADD, 48'({$urandom, $urandom}), $urandom);
      send_word(plr_pkg::OP_FINISH, '1, '1);
      send_word(plr_pkg::OP_ADD, 48'd0, 32'd0);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### greedy_plr_segmenter.f
rtl/plr_pkg.sv
rtl/plr_mul.sv
rtl/plr_div.sv
rtl/greedy_plr_segmenter.sv
bench/tb_greedy_plr_segmenter.sv
